// ----- src/pdp_pkg.sv -----
// ----------------------------------------------------------------------------
// pdp_pkg
// Shared types and constants of the polyline dash pattern plotter.
// ----------------------------------------------------------------------------
package pdp_pkg;

	localparam int COORD_BITS = 20;
	localparam int FRAC_BITS_DEF = 8;
	localparam int LEN_W = 12;
	localparam int STYLE_W = 3;

	localparam logic [LEN_W-1:0] DASH_RESET = 12'd16;
	localparam logic [LEN_W-1:0] DOT_RESET = 12'd4;
	localparam logic [LEN_W-1:0] GAP_RESET = 12'd24;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_VERTEX = 2'd1,
		REQ_STEP = 2'd2,
		REQ_LONE = 2'd3
	} req_e;

	typedef enum logic [STYLE_W-1:0] {
		STY_NONE = 3'd0,
		STY_SOLID = 3'd1,
		STY_DASH = 3'd2,
		STY_DOT = 3'd3,
		STY_DASHDOT = 3'd4,
		STY_DASHDOTDOT = 3'd5,
		STY_OTHER6 = 3'd6,
		STY_OTHER7 = 3'd7
	} style_e;

	typedef enum logic [1:0] {
		CFG_DASH = 2'd0,
		CFG_DOT = 2'd1,
		CFG_GAP = 2'd2
	} cfg_idx_e;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic [STYLE_W-1:0] line_style;
	} in_word_t;

	typedef struct packed {
		logic pen_down;
		logic has_coords;
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic more_pending;
	} out_word_t;

	typedef struct packed {
		req_e kind;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		style_e style;
	} cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0] dash;
		logic [LEN_W-1:0] dot;
		logic [LEN_W-1:0] gap;
	} cfg_t;

endpackage

// ----- src/pdp_front.sv -----
// ----------------------------------------------------------------------------
// pdp_front
// Accepts input words, classifies them into commands and queues two of them.
// ----------------------------------------------------------------------------
module pdp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pdp_pkg::in_word_t  in_word,
	output logic               cmd_valid,
	output pdp_pkg::cmd_t      cmd,
	input  logic               cmd_pop
);

	pdp_pkg::cmd_t fifo_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	pdp_pkg::cmd_t new_cmd;
	logic push;

	always_comb begin
		new_cmd.kind = pdp_pkg::req_e'(in_word.req_type);
		new_cmd.x = in_word.point_x;
		new_cmd.y = in_word.point_y;
		if (in_word.line_style == pdp_pkg::STY_OTHER6 ||
				in_word.line_style == pdp_pkg::STY_OTHER7) begin
			new_cmd.style = pdp_pkg::STY_SOLID;
		end else begin
			new_cmd.style = pdp_pkg::style_e'(in_word.line_style);
		end
	end

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- src/pdp_sqrt.sv -----
// ----------------------------------------------------------------------------
// pdp_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pdp_sqrt #(
	parameter int ROOT_W = 29
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   radicand,
	output logic                  busy,
	output logic [ROOT_W-1:0]     root
);

	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [2*ROOT_W-1:0] rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ROOT_W+3:0] rem_sh;
	logic [ROOT_W+3:0] trial;

	assign rem_sh = {rem_q, rad_q[2*ROOT_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign busy = (cnt_q != '0);
	assign root = root_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy) begin
			rad_q <= {rad_q[2*ROOT_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= (ROOT_W+2)'(rem_sh - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[ROOT_W+1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(ROOT_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

// ----- src/pdp_div.sv -----
// ----------------------------------------------------------------------------
// pdp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdp_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 29
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              busy,
	output logic [NUM_W-1:0]  quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] n_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0] r2;

	assign r2 = {rem_q, n_q[NUM_W-1]};
	assign busy = (cnt_q != '0);
	assign quot = n_q;

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy) begin
			if (r2 >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(r2 - {1'b0, den_q});
				n_q <= {n_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= r2[DEN_W-1:0];
				n_q <= {n_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

// ----- src/pdp_engine.sv -----
// ----------------------------------------------------------------------------
// pdp_engine
// Executes queued commands: pen moves, dash splitting and the output register.
// ----------------------------------------------------------------------------
module pdp_engine #(
	parameter int FRAC_BITS = pdp_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pdp_pkg::cfg_t       cfg,
	input  logic                cmd_valid,
	input  pdp_pkg::cmd_t       cmd,
	output logic                cmd_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output pdp_pkg::out_word_t  out_word
);

	localparam int C = pdp_pkg::COORD_BITS;
	localparam int MAG_W = C + FRAC_BITS;
	localparam int CUR_W = C + FRAC_BITS;
	localparam int DX_W = CUR_W + 1;
	localparam int SUM_W = 2 * MAG_W + 1;
	localparam int ROOT_W = MAG_W + 1;
	localparam int PL_W = pdp_pkg::LEN_W + FRAC_BITS;
	localparam int NUM_W = MAG_W + PL_W + 1;
	localparam int CMP_W = (ROOT_W > PL_W) ? ROOT_W : PL_W;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_SQX  = 14'b00000000000010,
		ST_SQY  = 14'b00000000000100,
		ST_SQS  = 14'b00000000001000,
		ST_ROOT = 14'b00000000010000,
		ST_CMP  = 14'b00000000100000,
		ST_MX   = 14'b00000001000000,
		ST_DSX  = 14'b00000010000000,
		ST_DX   = 14'b00000100000000,
		ST_MY   = 14'b00001000000000,
		ST_DSY  = 14'b00010000000000,
		ST_DY   = 14'b00100000000000,
		ST_RND  = 14'b01000000000000,
		ST_OUT  = 14'b10000000000000
	} state_t;

	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_SPLIT = 2'd1,
		PEND_BARE = 2'd2
	} pend_t;

	state_t state_q;
	pend_t pend_q;
	pdp_pkg::style_e style_q;
	logic phase_q;
	logic [2:0] slot_q;
	logic signed [CUR_W-1:0] cur_x_q, cur_y_q;
	logic signed [C-1:0] tgt_x_q, tgt_y_q;
	logic [PL_W-1:0] pl_q;
	logic signed [C-1:0] last_x_q, last_y_q;
	logic [MAG_W-1:0] magx_q, magy_q;
	logic negx_q, negy_q;
	logic [SUM_W-1:0] sum_q;
	logic [NUM_W-1:0] num_q;
	logic res_pen_q, res_bare_q, res_more_q;
	logic signed [C-1:0] res_x_q, res_y_q;
	pdp_pkg::out_word_t out_q;
	logic out_valid_q;

	logic [DX_W-1:0] dx, dy, ndx, ndy;
	logic [CUR_W-1:0] tfx, tfy;
	logic [pdp_pkg::LEN_W-1:0] elem_len;
	logic [2:0] slot_next, pat_size;
	logic [ROOT_W-1:0] root;
	logic [NUM_W-1:0] quot;
	logic sq_start, sq_busy, dv_start, dv_busy;
	logic [CMP_W-1:0] sub_c, pl_c;
	logic [MAG_W-1:0] q;
	logic [CUR_W:0] rx, ry;
	logic has;
	logic out_free;
	logic out_load;
	logic [MAG_W+PL_W-1:0] prod;
	logic [MAG_W-1:0] mag_dx, mag_dy;
	logic [2*MAG_W-1:0] sq_x, sq_y;

	assign tfx = {tgt_x_q, {FRAC_BITS{1'b0}}};
	assign tfy = {tgt_y_q, {FRAC_BITS{1'b0}}};
	assign dx = {tfx[CUR_W-1], tfx} - {cur_x_q[CUR_W-1], cur_x_q};
	assign dy = {tfy[CUR_W-1], tfy} - {cur_y_q[CUR_W-1], cur_y_q};
	assign ndx = -dx;
	assign ndy = -dy;
	assign mag_dx = dx[DX_W-1] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
	assign mag_dy = dy[DX_W-1] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
	assign sq_x = mag_dx * mag_dx;
	assign sq_y = magy_q * magy_q;

	always_comb begin
		if (!phase_q) begin
			elem_len = cfg.gap;
		end else if (slot_q == 3'd0 && style_q != pdp_pkg::STY_DOT) begin
			elem_len = cfg.dash;
		end else begin
			elem_len = cfg.dot;
		end
		if (elem_len == '0) begin
			elem_len = pdp_pkg::LEN_W'(1);
		end
		case (style_q)
			pdp_pkg::STY_DASHDOT:    pat_size = 3'd4;
			pdp_pkg::STY_DASHDOTDOT: pat_size = 3'd6;
			default:                 pat_size = 3'd2;
		endcase
		slot_next = ((slot_q + 3'd2) == pat_size) ? 3'd0 : slot_q + 3'd2;
	end

	assign sub_c = CMP_W'(root);
	assign pl_c = CMP_W'(pl_q);
	assign q = quot[MAG_W-1:0];
	assign prod = (state_q == ST_MX) ? magx_q * pl_q : magy_q * pl_q;
	assign rx = {cur_x_q[CUR_W-1], cur_x_q} + ((CUR_W+1)'(1) << (FRAC_BITS - 1));
	assign ry = {cur_y_q[CUR_W-1], cur_y_q} + ((CUR_W+1)'(1) << (FRAC_BITS - 1));
	assign has = !res_bare_q && (res_x_q != last_x_q || res_y_q != last_y_q);
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == ST_OUT) && out_free;
	assign sq_start = (state_q == ST_SQS);
	assign dv_start = (state_q == ST_DSX) || (state_q == ST_DSY);
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign out_valid = out_valid_q;
	assign out_word = out_q;

	pdp_sqrt #(
		.ROOT_W(ROOT_W)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.radicand({1'b0, sum_q}),
		.busy(sq_busy),
		.root(root)
	);

	pdp_div #(
		.NUM_W(NUM_W),
		.DEN_W(ROOT_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(dv_start),
		.num(num_q),
		.den(root),
		.busy(dv_busy),
		.quot(quot)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SQX: begin
				negx_q <= dx[DX_W-1];
				negy_q <= dy[DX_W-1];
				magx_q <= mag_dx;
				magy_q <= mag_dy;
				sum_q <= SUM_W'(sq_x);
			end
			ST_SQY: begin
				sum_q <= sum_q + SUM_W'(sq_y);
			end
			ST_MX, ST_MY: begin
				num_q <= NUM_W'(prod) + NUM_W'(root >> 1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= PEND_NONE;
			style_q <= pdp_pkg::STY_NONE;
			phase_q <= 1'b1;
			slot_q <= 3'd0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			pl_q <= '0;
			last_x_q <= '1;
			last_y_q <= '1;
			res_pen_q <= 1'b0;
			res_bare_q <= 1'b0;
			res_more_q <= 1'b0;
			res_x_q <= '0;
			res_y_q <= '0;
			out_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						res_bare_q <= 1'b0;
						res_x_q <= cmd.x;
						res_y_q <= cmd.y;
						res_more_q <= 1'b0;
						unique case (cmd.kind)
							pdp_pkg::REQ_START: begin
								pend_q <= PEND_NONE;
								style_q <= cmd.style;
								cur_x_q <= {cmd.x, {FRAC_BITS{1'b0}}};
								cur_y_q <= {cmd.y, {FRAC_BITS{1'b0}}};
								tgt_x_q <= cmd.x;
								tgt_y_q <= cmd.y;
								pl_q <= '0;
								phase_q <= 1'b1;
								slot_q <= 3'd0;
								res_pen_q <= 1'b0;
								if (cmd.style != pdp_pkg::STY_NONE) begin
									state_q <= ST_OUT;
								end
							end
							pdp_pkg::REQ_VERTEX: begin
								pend_q <= PEND_NONE;
								tgt_x_q <= cmd.x;
								tgt_y_q <= cmd.y;
								res_pen_q <= 1'b1;
								if (style_q == pdp_pkg::STY_DASH || style_q == pdp_pkg::STY_DOT ||
										style_q == pdp_pkg::STY_DASHDOT ||
										style_q == pdp_pkg::STY_DASHDOTDOT) begin
									state_q <= ST_SQX;
								end else begin
									cur_x_q <= {cmd.x, {FRAC_BITS{1'b0}}};
									cur_y_q <= {cmd.y, {FRAC_BITS{1'b0}}};
									if (style_q != pdp_pkg::STY_NONE) begin
										state_q <= ST_OUT;
									end
								end
							end
							pdp_pkg::REQ_STEP: begin
								if (pend_q == PEND_SPLIT) begin
									state_q <= ST_SQX;
								end else if (pend_q == PEND_BARE) begin
									pend_q <= PEND_NONE;
									res_pen_q <= 1'b1;
									res_bare_q <= 1'b1;
									res_x_q <= '0;
									res_y_q <= '0;
									state_q <= ST_OUT;
								end
							end
							pdp_pkg::REQ_LONE: begin
								pend_q <= PEND_NONE;
								res_pen_q <= 1'b0;
								res_more_q <= 1'b1;
								if (cmd.style != pdp_pkg::STY_NONE) begin
									cur_x_q <= {cmd.x, {FRAC_BITS{1'b0}}};
									cur_y_q <= {cmd.y, {FRAC_BITS{1'b0}}};
									tgt_x_q <= cmd.x;
									tgt_y_q <= cmd.y;
									pend_q <= PEND_BARE;
									state_q <= ST_OUT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SQX: begin
					if (pl_q == '0) begin
						pl_q <= {elem_len, {FRAC_BITS{1'b0}}};
					end
					state_q <= ST_SQY;
				end
				ST_SQY: state_q <= ST_SQS;
				ST_SQS: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (!sq_busy) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					res_bare_q <= 1'b0;
					res_more_q <= 1'b0;
					res_x_q <= tgt_x_q;
					res_y_q <= tgt_y_q;
					res_pen_q <= phase_q;
					if (sub_c < pl_c) begin
						pl_q <= PL_W'(pl_c - sub_c);
						cur_x_q <= tfx;
						cur_y_q <= tfy;
						pend_q <= PEND_NONE;
						state_q <= phase_q ? ST_OUT : ST_IDLE;
					end else if (sub_c == pl_c) begin
						cur_x_q <= tfx;
						cur_y_q <= tfy;
						pl_q <= '0;
						pend_q <= PEND_NONE;
						if (phase_q) begin
							phase_q <= 1'b0;
						end else begin
							phase_q <= 1'b1;
							slot_q <= slot_next;
						end
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MX;
					end
				end
				ST_MX: state_q <= ST_DSX;
				ST_DSX: state_q <= ST_DX;
				ST_DX: begin
					if (!dv_busy) begin
						cur_x_q <= negx_q ? cur_x_q - q : cur_x_q + q;
						state_q <= ST_MY;
					end
				end
				ST_MY: state_q <= ST_DSY;
				ST_DSY: state_q <= ST_DY;
				ST_DY: begin
					if (!dv_busy) begin
						cur_y_q <= negy_q ? cur_y_q - q : cur_y_q + q;
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					res_x_q <= rx[FRAC_BITS +: C];
					res_y_q <= ry[FRAC_BITS +: C];
					res_more_q <= 1'b1;
					pl_q <= '0;
					pend_q <= PEND_SPLIT;
					if (phase_q) begin
						phase_q <= 1'b0;
					end else begin
						phase_q <= 1'b1;
						slot_q <= slot_next;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_q.pen_down <= res_pen_q;
						out_q.has_coords <= has;
						out_q.out_x <= has ? res_x_q : '0;
						out_q.out_y <= has ? res_y_q : '0;
						out_q.more_pending <= res_more_q;
						if (has) begin
							last_x_q <= res_x_q;
							last_y_q <= res_y_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/polyline_dash_pattern_plotter.sv -----
// ----------------------------------------------------------------------------
// polyline_dash_pattern_plotter
// Turns polyline vertices into pen-up and pen-down moves in a dash style.
// ----------------------------------------------------------------------------
// Input words (start, vertex, step, lone point) arrive on the in_valid /
// in_ready channel and enter a two-word command queue. Moves leave on the
// out_valid / out_ready channel from an output register, so the engine may
// finish the next command while a move still waits to be taken; a stalled
// receiver only holds the engine once it has a further move to deliver.
// Start, solid vertex, lone point and bare step words pass only through the
// engine's idle and output states. A dashed vertex or split step runs the
// square root unit and, when a boundary falls inside the segment, the
// bit-serial divider twice, once for each axis.
// The dash, dot and gap lengths are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while the block is idle, since the
// block itself does not enforce it. Reset empties the queue and the output
// register, restores lengths 16, 4 and 24, selects style none and forgets
// the last pen position.
// ----------------------------------------------------------------------------
module polyline_dash_pattern_plotter #(
	parameter int FRAC_BITS = pdp_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pdp_pkg::in_word_t             in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pdp_pkg::out_word_t            out_word,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [pdp_pkg::LEN_W-1:0]     cfg_data
);

	pdp_pkg::cfg_t cfg_q;
	logic cmd_valid;
	logic cmd_pop;
	pdp_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dash <= pdp_pkg::DASH_RESET;
			cfg_q.dot <= pdp_pkg::DOT_RESET;
			cfg_q.gap <= pdp_pkg::GAP_RESET;
		end else if (cfg_we) begin
			unique case (pdp_pkg::cfg_idx_e'(cfg_index))
				pdp_pkg::CFG_DASH: cfg_q.dash <= cfg_data;
				pdp_pkg::CFG_DOT:  cfg_q.dot <= cfg_data;
				pdp_pkg::CFG_GAP:  cfg_q.gap <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pdp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	pdp_engine #(
		.FRAC_BITS(FRAC_BITS)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives start, vertex, step and lone point words into the plotter and checks
// every move against a cycle-free model of the dash splitting, over several
// dash, dot and gap length settings and with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE = 200;
	localparam int PHASE_ITEMS = 190;

	typedef enum int {PEND_NONE, PEND_SPLIT, PEND_BARE} pend_e;

	typedef struct {
		pdp_pkg::in_word_t word;
		bit typed;
		bit got;
		pdp_pkg::out_word_t move;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pdp_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pdp_pkg::out_word_t out_word;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = pdp_pkg::CFG_DASH;
	logic [pdp_pkg::LEN_W-1:0] cfg_data = '0;

	polyline_dash_pattern_plotter DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	pdp_pkg::out_word_t moves_due[$];
	int errors = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit steady = 0;
	int produced = 0;

	int unsigned len_dash = 16, len_dot = 4, len_gap = 24;
	longint cur_x, cur_y, tgt_x, tgt_y, last_x, last_y;
	longint unsigned seg_left, pat_left;
	bit dash_on;
	int slot;
	pdp_pkg::style_e path_style;
	pend_e pend;

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint scale_axis(longint d, longint unsigned num, longint unsigned den);
		longint unsigned m = d < 0 ? -d : d;
		longint unsigned q = (m * num + den / 2) / den;
		return d < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned element_len();
		int unsigned len;
		if (!dash_on)
			len = len_gap;
		else if (slot == 0 && path_style != pdp_pkg::STY_DOT)
			len = len_dash;
		else
			len = len_dot;
		return len == 0 ? 1 : len;
	endfunction

	task automatic make_move(bit pen, longint x, longint y, bit more,
			output pdp_pkg::out_word_t r);
		bit moved = (x != last_x) || (y != last_y);
		r.pen_down = pen;
		r.has_coords = moved;
		r.out_x = moved ? x[pdp_pkg::COORD_BITS-1:0] : '0;
		r.out_y = moved ? y[pdp_pkg::COORD_BITS-1:0] : '0;
		r.more_pending = more;
		if (moved) begin
			last_x = x;
			last_y = y;
		end
	endtask

	task automatic next_element();
		int size = path_style == pdp_pkg::STY_DASHDOT ? 4 :
			(path_style == pdp_pkg::STY_DASHDOTDOT ? 6 : 2);
		if (dash_on) begin
			dash_on = 0;
		end else begin
			dash_on = 1;
			slot = (slot + 2) % size;
		end
	endtask

	task automatic split_segment(output bit got, output pdp_pkg::out_word_t r);
		longint fx = tgt_x * 256;
		longint fy = tgt_y * 256;
		longint dx = fx - cur_x;
		longint dy = fy - cur_y;
		longint unsigned mx = dx < 0 ? -dx : dx;
		longint unsigned my = dy < 0 ? -dy : dy;
		longint unsigned seg_len = int_root(mx * mx + my * my);
		bit pen = dash_on;
		got = 0;
		if (pat_left == 0)
			pat_left = element_len() << 8;
		if (seg_len < pat_left) begin
			pat_left -= seg_len;
			cur_x = fx;
			cur_y = fy;
			seg_left = 0;
			pend = PEND_NONE;
			if (pen) begin
				make_move(1, tgt_x, tgt_y, 0, r);
				got = 1;
			end
		end else if (seg_len == pat_left) begin
			cur_x = fx;
			cur_y = fy;
			seg_left = 0;
			pat_left = 0;
			pend = PEND_NONE;
			next_element();
			make_move(pen, tgt_x, tgt_y, 0, r);
			got = 1;
		end else begin
			cur_x += scale_axis(dx, pat_left, seg_len);
			cur_y += scale_axis(dy, pat_left, seg_len);
			seg_left = seg_len - pat_left;
			pat_left = 0;
			pend = PEND_SPLIT;
			next_element();
			make_move(pen, (cur_x + 128) >>> 8, (cur_y + 128) >>> 8, 1, r);
			got = 1;
		end
	endtask

	task automatic plot_word(pdp_pkg::in_word_t w, output bit got,
			output pdp_pkg::out_word_t r);
		longint px = longint'(signed'(w.point_x));
		longint py = longint'(signed'(w.point_y));
		pdp_pkg::style_e sty = pdp_pkg::style_e'(w.line_style);
		got = 0;
		r = '0;
		case (pdp_pkg::req_e'(w.req_type))
			pdp_pkg::REQ_START: begin
				pend = PEND_NONE;
				path_style = sty;
				cur_x = px * 256;
				cur_y = py * 256;
				tgt_x = px;
				tgt_y = py;
				seg_left = 0;
				pat_left = 0;
				dash_on = 1;
				slot = 0;
				if (sty != pdp_pkg::STY_NONE) begin
					make_move(0, px, py, 0, r);
					got = 1;
				end
			end
			pdp_pkg::REQ_VERTEX: begin
				pend = PEND_NONE;
				tgt_x = px;
				tgt_y = py;
				if (path_style >= pdp_pkg::STY_DASH &&
						path_style <= pdp_pkg::STY_DASHDOTDOT) begin
					split_segment(got, r);
				end else begin
					cur_x = px * 256;
					cur_y = py * 256;
					seg_left = 0;
					if (path_style != pdp_pkg::STY_NONE) begin
						make_move(1, px, py, 0, r);
						got = 1;
					end
				end
			end
			pdp_pkg::REQ_STEP: begin
				if (pend == PEND_SPLIT) begin
					split_segment(got, r);
				end else if (pend == PEND_BARE) begin
					pend = PEND_NONE;
					r.pen_down = 1;
					got = 1;
				end
			end
			default: begin
				pend = PEND_NONE;
				if (sty != pdp_pkg::STY_NONE) begin
					cur_x = px * 256;
					cur_y = py * 256;
					tgt_x = px;
					tgt_y = py;
					seg_left = 0;
					pend = PEND_BARE;
					make_move(0, px, py, 1, r);
					got = 1;
				end
			end
		endcase
	endtask

	function automatic int pick_gap();
		if (steady)
			return 0;
		if ($urandom_range(15) == 0)
			return $urandom_range(60, 10);
		return $urandom_range(2) == 0 ? 0 : $urandom_range(3, 1);
	endfunction

	task automatic send(pdp_pkg::in_word_t w, bit typed = 0, bit t_got = 0,
			pdp_pkg::out_word_t t_move = '0);
		int gap = pick_gap();
		bit got;
		pdp_pkg::out_word_t r;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		plot_word(w, got, r);
		if (typed) begin
			got = t_got;
			r = t_move;
		end
		if (got)
			moves_due.push_back(r);
		produced++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (moves_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_len(pdp_pkg::cfg_idx_e idx, logic [pdp_pkg::LEN_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pdp_pkg::CFG_DASH: len_dash = val;
			pdp_pkg::CFG_DOT: len_dot = val;
			default: len_gap = val;
		endcase
	endtask

	function automatic pdp_pkg::in_word_t mk(pdp_pkg::req_e k, int x, int y,
			pdp_pkg::style_e s);
		pdp_pkg::in_word_t w;
		w.req_type = k;
		w.point_x = x[pdp_pkg::COORD_BITS-1:0];
		w.point_y = y[pdp_pkg::COORD_BITS-1:0];
		w.line_style = s;
		return w;
	endfunction

	function automatic pdp_pkg::out_word_t mv(bit pen, bit has, int x, int y, bit more);
		pdp_pkg::out_word_t r;
		r.pen_down = pen;
		r.has_coords = has;
		r.out_x = x[pdp_pkg::COORD_BITS-1:0];
		r.out_y = y[pdp_pkg::COORD_BITS-1:0];
		r.more_pending = more;
		return r;
	endfunction

	function automatic int near(int v, int span);
		int n = v + int'($urandom_range(2 * span)) - span;
		if (n > 524287)
			n = 524287;
		if (n < -524288)
			n = -524288;
		return n;
	endfunction

	task automatic random_path();
		pdp_pkg::style_e s;
		int x, y, steps;
		pdp_pkg::in_word_t w;
		if ($urandom_range(9) == 0) begin
			w = pdp_pkg::in_word_t'({$urandom, $urandom});
			send(w);
			return;
		end
		s = $urandom_range(3) == 0 ? pdp_pkg::style_e'($urandom_range(7)) :
			pdp_pkg::style_e'($urandom_range(5, 2));
		x = $urandom_range(7) == 0 ? int'($urandom_range(1048575)) - 524288 : near(0, 2000);
		y = $urandom_range(7) == 0 ? int'($urandom_range(1048575)) - 524288 : near(0, 2000);
		if ($urandom_range(7) == 0) begin
			send(mk(pdp_pkg::REQ_LONE, x, y, s));
			send(mk(pdp_pkg::REQ_STEP, x, y, pdp_pkg::style_e'($urandom_range(7))));
			return;
		end
		send(mk(pdp_pkg::REQ_START, x, y, s));
		repeat ($urandom_range(5, 1)) begin
			if (produced >= PHASE_ITEMS)
				break;
			x = near(x, $urandom_range(3) == 0 ? 4000 : 150);
			y = near(y, $urandom_range(3) == 0 ? 4000 : 150);
			send(mk(pdp_pkg::REQ_VERTEX, x, y, pdp_pkg::style_e'($urandom_range(7))));
			steps = $urandom_range(4) == 0 ? $urandom_range(6) : 40;
			while (pend == PEND_SPLIT && steps > 0 && produced < PHASE_ITEMS) begin
				send(mk(pdp_pkg::REQ_STEP, $urandom, $urandom,
					pdp_pkg::style_e'($urandom_range(7))));
				steps--;
			end
		end
	endtask

	row_t rows[] = '{
		'{mk(pdp_pkg::REQ_VERTEX, 9, 9, pdp_pkg::STY_SOLID), 1, 0, '0},
		'{mk(pdp_pkg::REQ_START, 524287, 524287, pdp_pkg::STY_SOLID), 1, 1,
			mv(0, 1, 524287, 524287, 0)},
		'{mk(pdp_pkg::REQ_VERTEX, -524288, -524288, pdp_pkg::STY_NONE), 1, 1,
			mv(1, 1, -524288, -524288, 0)},
		'{mk(pdp_pkg::REQ_VERTEX, -524288, -524288, pdp_pkg::STY_DASH), 1, 1,
			mv(1, 0, 0, 0, 0)},
		'{mk(pdp_pkg::REQ_LONE, 3, 3, pdp_pkg::STY_NONE), 1, 0, '0},
		'{mk(pdp_pkg::REQ_STEP, 0, 0, pdp_pkg::STY_SOLID), 1, 0, '0},
		'{mk(pdp_pkg::REQ_LONE, 5, -7, pdp_pkg::STY_SOLID), 1, 1, mv(0, 1, 5, -7, 1)},
		'{mk(pdp_pkg::REQ_STEP, 0, 0, pdp_pkg::STY_NONE), 1, 1, mv(1, 0, 0, 0, 0)},
		'{mk(pdp_pkg::REQ_STEP, 0, 0, pdp_pkg::STY_NONE), 1, 0, '0},
		'{mk(pdp_pkg::REQ_START, 0, 0, pdp_pkg::STY_NONE), 1, 0, '0},
		'{mk(pdp_pkg::REQ_START, 0, 0, pdp_pkg::STY_DASH), 1, 1, mv(0, 1, 0, 0, 0)},
		'{mk(pdp_pkg::REQ_VERTEX, 100, 30, pdp_pkg::STY_DASH), 0, 0, '0},
		'{mk(pdp_pkg::REQ_STEP, 0, 0, pdp_pkg::STY_DASH), 0, 0, '0},
		'{mk(pdp_pkg::REQ_STEP, 0, 0, pdp_pkg::STY_DASH), 0, 0, '0},
		'{mk(pdp_pkg::REQ_VERTEX, -40, 60, pdp_pkg::STY_DASH), 0, 0, '0},
		'{mk(pdp_pkg::REQ_START, 0, 0, pdp_pkg::STY_DASH), 0, 0, '0},
		'{mk(pdp_pkg::REQ_VERTEX, 16, 0, pdp_pkg::STY_DASH), 0, 0, '0},
		'{mk(pdp_pkg::REQ_VERTEX, 20, 0, pdp_pkg::STY_DASH), 0, 0, '0},
		'{mk(pdp_pkg::REQ_START, 10, 10, pdp_pkg::STY_DOT), 0, 0, '0},
		'{mk(pdp_pkg::REQ_VERTEX, 10, 70, pdp_pkg::STY_DOT), 0, 0, '0},
		'{mk(pdp_pkg::REQ_START, -50, 0, pdp_pkg::STY_DASHDOT), 0, 0, '0},
		'{mk(pdp_pkg::REQ_VERTEX, 150, -90, pdp_pkg::STY_DASHDOT), 0, 0, '0},
		'{mk(pdp_pkg::REQ_START, 0, -50, pdp_pkg::STY_DASHDOTDOT), 0, 0, '0},
		'{mk(pdp_pkg::REQ_VERTEX, -200, 120, pdp_pkg::STY_DASHDOTDOT), 0, 0, '0},
		'{mk(pdp_pkg::REQ_START, 1, 1, pdp_pkg::STY_OTHER7), 0, 0, '0}
	};

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady && $urandom_range(3) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(9) == 0 ? $urandom_range(60, 10) : $urandom_range(3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pdp_pkg::out_word_t want;
		if (out_valid && out_ready) begin
			if (moves_due.size() == 0) begin
				$display("%0t: unexpected move, actual %p", $time, out_word);
				errors++;
			end else begin
				want = moves_due.pop_front();
				if (out_word !== want) begin
					$display("%0t: move mismatch, expected %p, actual %p", $time, want, out_word);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		cur_x = 0; cur_y = 0; tgt_x = 0; tgt_y = 0;
		seg_left = 0; pat_left = 0; dash_on = 1; slot = 0;
		path_style = pdp_pkg::STY_NONE; last_x = -1; last_y = -1; pend = PEND_NONE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send(rows[i].word, rows[i].typed, rows[i].got, rows[i].move);
		for (int p = 0; p < 5; p++) begin
			settle();
			case (p)
				1: begin
					write_len(pdp_pkg::CFG_DASH, 12'd1);
					write_len(pdp_pkg::CFG_DOT, 12'd1);
					write_len(pdp_pkg::CFG_GAP, 12'd1);
				end
				2: begin
					write_len(pdp_pkg::CFG_DASH, 12'd4095);
					write_len(pdp_pkg::CFG_DOT, 12'd4095);
					write_len(pdp_pkg::CFG_GAP, 12'd4095);
				end
				3: begin
					write_len(pdp_pkg::CFG_DASH, 12'd0);
					write_len(pdp_pkg::CFG_DOT, 12'd0);
					write_len(pdp_pkg::CFG_GAP, 12'd0);
				end
				4: begin
					write_len(pdp_pkg::CFG_DASH, $urandom_range(200, 1));
					write_len(pdp_pkg::CFG_DOT, $urandom_range(50, 1));
					write_len(pdp_pkg::CFG_GAP, $urandom_range(200, 1));
				end
				default: ;
			endcase
			steady = $urandom_range(3) == 0;
			produced = 0;
			while (produced < PHASE_ITEMS)
				random_path();
			steady = 0;
		end
		settle();
		if (errors == 0 && moves_due.size() == 0) begin
			$display("testbench passed");
		end else begin
			if (moves_due.size() != 0)
				$display("%0t: %0d moves never arrived", $time, moves_due.size());
			$display("testbench failed");
		end
		$finish;
	end

endmodule
